// ----- rtl/i2cmbs_pkg.sv -----
// Shared command codes and constants for the I2C master bit sequencer.
package i2cmbs_pkg;

    localparam int CMD_W     = 2;
    localparam int DATA_W    = 8;
    localparam int BIT_CNT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(DATA_W - 1);

endpackage

// ----- rtl/i2c_master_bit_sequencer_top.sv -----
// I2C master wire sequencer: one command in, a train of SCL/SDA wire steps out.
//
// Each accepted command (start, stop, write byte, read byte) is expanded into
// wire steps, one result transfer per step, with last_step marking the final
// one. The step sequencer issues at most one step per cycle through the output
// register, holding while the output side stalls, and a single 8-bit rotate
// register serves both the write shift-out and the read assembly. s_ready is
// high only between commands. SCL and SDA levels persist across commands and
// reset to released high; the write acknowledge level and the read sample bits
// are taken from the command itself.
module i2c_master_bit_sequencer_top
    import i2cmbs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_command,
    input  logic [DATA_W-1:0]    s_write_data,
    input  logic [DATA_W-1:0]    s_read_sda_bits,
    input  logic                 s_ack_sda,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_scl_level,
    output logic                 m_sda_level,
    output logic [DATA_W-1:0]    m_read_data,
    output logic                 m_ack_failed,
    output logic                 m_last_step
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_STA_SDA1, ST_STA_SCL1, ST_STA_SDA0, ST_STA_SCL0,
        ST_STP_SDA0, ST_STP_SCL1, ST_STP_SDA1,
        ST_WR_BIT, ST_WR_SCLH, ST_WR_SCLL, ST_WR_REL, ST_WR_ACKH, ST_WR_ACKL,
        ST_RD_REL, ST_RD_SCLH, ST_RD_SCLL, ST_RD_ACK0, ST_RD_ACKH, ST_RD_ACKL,
        ST_RD_END
    } state_t;

    state_t                state_reg, state_next;
    logic [DATA_W-1:0]     data_reg, data_next;
    logic [BIT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  ack_reg, ack_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic [DATA_W-1:0]     rdata_reg, rdata_next;
    logic                  afail_reg, afail_next;
    logic                  last_reg, last_next;
    logic                  in_xfer;
    logic                  emit;
    logic [DATA_W-1:0]     data_rot;

    assign s_ready      = (state_reg == ST_IDLE);
    assign in_xfer      = s_valid && s_ready;
    assign emit         = (state_reg != ST_IDLE) && (!m_valid_reg || m_ready);
    // Shared rotate unit: shifts the write byte out and reassembles the read byte
    assign data_rot     = {data_reg[DATA_W-2:0], data_reg[DATA_W-1]};

    assign m_valid      = m_valid_reg;
    assign m_scl_level  = scl_reg;
    assign m_sda_level  = sda_reg;
    assign m_read_data  = rdata_reg;
    assign m_ack_failed = afail_reg;
    assign m_last_step  = last_reg;

    // Work out the next step and sequencer state
    always_comb begin
        state_next   = state_reg;
        data_next    = data_reg;
        cnt_next     = cnt_reg;
        ack_next     = ack_reg;
        m_valid_next = m_valid_reg && !m_ready;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rdata_next   = rdata_reg;
        afail_next   = afail_reg;
        last_next    = last_reg;

        if (in_xfer) begin
            cnt_next = '0;
            ack_next = s_ack_sda;
            case (cmd_t'(s_command))
                CMD_START: begin
                    state_next = ST_STA_SDA1;
                end
                CMD_STOP: begin
                    state_next = ST_STP_SDA0;
                end
                CMD_WRITE: begin
                    state_next = ST_WR_BIT;
                    data_next  = s_write_data;
                end
                default: begin
                    state_next = ST_RD_REL;
                    data_next  = s_read_sda_bits;
                end
            endcase
        end

        if (emit) begin
            m_valid_next = 1'b1;
            rdata_next   = '0;
            afail_next   = 1'b0;
            last_next    = 1'b0;
            case (state_reg)
                ST_STA_SDA1: begin
                    sda_next   = 1'b1;
                    state_next = ST_STA_SCL1;
                end
                ST_STA_SCL1: begin
                    scl_next   = 1'b1;
                    state_next = ST_STA_SDA0;
                end
                ST_STA_SDA0: begin
                    sda_next   = 1'b0;
                    state_next = ST_STA_SCL0;
                end
                ST_STA_SCL0: begin
                    scl_next   = 1'b0;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                ST_STP_SDA0: begin
                    sda_next   = 1'b0;
                    state_next = ST_STP_SCL1;
                end
                ST_STP_SCL1: begin
                    scl_next   = 1'b1;
                    state_next = ST_STP_SDA1;
                end
                ST_STP_SDA1: begin
                    sda_next   = 1'b1;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                ST_WR_BIT: begin
                    sda_next   = data_reg[DATA_W-1];
                    state_next = ST_WR_SCLH;
                end
                ST_WR_SCLH: begin
                    scl_next   = 1'b1;
                    state_next = ST_WR_SCLL;
                end
                ST_WR_SCLL: begin
                    scl_next   = 1'b0;
                    data_next  = data_rot;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = (cnt_reg == LAST_BIT) ? ST_WR_REL : ST_WR_BIT;
                end
                ST_WR_REL: begin
                    sda_next   = 1'b1;
                    state_next = ST_WR_ACKH;
                end
                ST_WR_ACKH: begin
                    scl_next   = 1'b1;
                    state_next = ST_WR_ACKL;
                end
                ST_WR_ACKL: begin
                    scl_next   = 1'b0;
                    afail_next = ack_reg;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                ST_RD_REL: begin
                    sda_next   = 1'b1;
                    state_next = ST_RD_SCLH;
                end
                ST_RD_SCLH: begin
                    // Sample point: take in the next bit
                    scl_next   = 1'b1;
                    data_next  = data_rot;
                    state_next = ST_RD_SCLL;
                end
                ST_RD_SCLL: begin
                    scl_next   = 1'b0;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = (cnt_reg == LAST_BIT) ? ST_RD_ACK0 : ST_RD_SCLH;
                end
                ST_RD_ACK0: begin
                    sda_next   = 1'b0;
                    state_next = ST_RD_ACKH;
                end
                ST_RD_ACKH: begin
                    scl_next   = 1'b1;
                    state_next = ST_RD_ACKL;
                end
                ST_RD_ACKL: begin
                    scl_next   = 1'b0;
                    state_next = ST_RD_END;
                end
                ST_RD_END: begin
                    sda_next   = 1'b1;
                    rdata_next = data_reg;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            cnt_reg     <= cnt_next;
        end
        data_reg  <= data_next;
        ack_reg   <= ack_next;
        rdata_reg <= rdata_next;
        afail_reg <= afail_next;
        last_reg  <= last_next;
    end

endmodule
